@@ design/svwp_pkg.sv @@
// ----------------------------------------------------------------------------
// Splat weight vertex painter package
// Shared payload types, register codes and pipeline item layout.
// ----------------------------------------------------------------------------
package svwp_pkg;

    // Paint mode codes.
    localparam logic [1:0] MODE_TEX  = 2'd0;
    localparam logic [1:0] MODE_DIF  = 2'd1;
    localparam logic [1:0] MODE_BOTH = 2'd2;

    // Register reset values.
    localparam logic [1:0]  RST_PAINT_MODE   = MODE_BOTH;
    localparam logic [1:0]  RST_ACTIVE_LAYER = 2'd0;
    localparam logic [7:0]  RST_TEXTURE_ID   = 8'd0;
    localparam logic [31:0] RST_PAINT_COLOR  = 32'h80FF_FFFF;

    localparam int NUM_LAYERS = 3;
    localparam int NUM_LANES  = 4;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PAINT_MODE   = 2'd0,
        CFG_ACTIVE_LAYER = 2'd1,
        CFG_TEXTURE_ID   = 2'd2,
        CFG_PAINT_COLOR  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_cfg_reg    index;
        logic [31:0] wdata;
    } t_cfg_wr;

    typedef struct packed {
        logic [7:0]  weight_0;
        logic [7:0]  weight_1;
        logic [7:0]  weight_2;
        logic [7:0]  index_0;
        logic [7:0]  index_1;
        logic [7:0]  index_2;
        logic [31:0] vtx_rgba;
        logic [9:0]  influence_q8;
    } t_vtx_in;

    typedef struct packed {
        logic [7:0]  new_weight_0;
        logic [7:0]  new_weight_1;
        logic [7:0]  new_weight_2;
        logic [7:0]  new_index_0;
        logic [7:0]  new_index_1;
        logic [7:0]  new_index_2;
        logic [31:0] new_color;
        logic        weights_changed;
    } t_vtx_out;

    // One vertex in flight through the pipeline.
    typedef struct packed {
        logic                  dif;
        logic                  chg;
        logic [1:0]            act;
        logic                  neg;
        logic [7:0]            mag;
        logic [2:0][7:0]       w;
        logic [2:0][7:0]       idx;
        logic [9:0]            den;
        logic [2:0][17:0]      rem;
        logic [2:0][7:0]       quo;
        logic [31:0]           color;
        logic [3:0][19:0]      bl;
    } t_item;

endpackage

@@ design/svwp_chan_if.sv @@
// ----------------------------------------------------------------------------
// Splat weight vertex painter channel
// Valid/ready channel carrying one payload beat of a given type.
// ----------------------------------------------------------------------------
interface svwp_chan_if #(parameter type t_data = logic);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/splat_weight_vertex_painter_unit.sv @@
// ----------------------------------------------------------------------------
// Splat weight vertex painter
// Paints texture splat weights and diffuse color of one terrain vertex.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                      Beat accepted when
//  i_vtx    in         weights, indices, color, q   i_vtx.valid && i_vtx.ready
//  o_vtx    out        painted vertex, changed flag o_vtx.valid && o_vtx.ready
//  i_cfg    in         register index, write data   i_cfg.valid && i_cfg.ready
//
// The datapath is a 13 stage pipeline; one vertex can enter every cycle
// while i_vtx.ready is high.
// The depth is set by two 8-bit quotient divisions (proportional loss and
// renormalization), each worked two bits per stage over four stages.
// Every stage holds its beat until the next stage is free, so a stall on
// o_vtx fills the bubbles first and only then drops i_vtx.ready.
// Reset clears the stage valid bits and loads the register reset values.
//
module splat_weight_vertex_painter_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    svwp_chan_if.sink           i_vtx,
    svwp_chan_if.source         o_vtx,
    svwp_chan_if.sink           i_cfg
);
    import svwp_pkg::*;

    localparam int NSTG      = 13;
    localparam int STG_MUL1  = 1;  // proportional-loss products, color blend
    localparam int STG_DIV1  = 2;  // first division, four stages
    localparam int STG_LOSS  = 6;  // apply loss, form weight sum
    localparam int STG_MUL2  = 7;  // products for renormalization
    localparam int STG_DIV2  = 8;  // second division, four stages
    localparam int STG_NORM  = 12; // pick renormalized weights
    localparam int DIV_STGS  = 4;

    // Registers: user changes them only while pipeline is empty; not enforced.
    logic [1:0]  r_paint_mode;
    logic [1:0]  r_active_layer;
    logic [7:0]  r_texture_id;
    logic [31:0] r_paint_color;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paint_mode   <= RST_PAINT_MODE;
            r_active_layer <= RST_ACTIVE_LAYER;
            r_texture_id   <= RST_TEXTURE_ID;
            r_paint_color  <= RST_PAINT_COLOR;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_PAINT_MODE:   r_paint_mode   <= i_cfg.data.wdata[1:0];
                CFG_ACTIVE_LAYER: r_active_layer <= i_cfg.data.wdata[1:0];
                CFG_TEXTURE_ID:   r_texture_id   <= i_cfg.data.wdata[7:0];
                CFG_PAINT_COLOR:  r_paint_color  <= i_cfg.data.wdata;
                default: ;
            endcase
        end
    end

    // Stage 0: step from influence, active layer update, color products.
    function automatic t_item stage_first(input t_vtx_in v, input logic [1:0] mode,
                                          input logic [1:0] act, input logic [7:0] tex_id,
                                          input logic [31:0] pcol);
        t_item              x;
        logic               tex;
        logic signed [9:0]  qs;
        logic signed [9:0]  qc;
        logic signed [17:0] n18;
        logic signed [9:0]  stp;
        logic signed [10:0] t11;
        logic [9:0]         tot;
        logic signed [8:0]  df;
        logic signed [18:0] pr;
        x = '0;
        x.w   = {v.weight_2, v.weight_1, v.weight_0};
        x.idx = {v.index_2, v.index_1, v.index_0};
        x.color = v.vtx_rgba;
        x.act = act;
        tex   = (mode == MODE_TEX || mode == MODE_BOTH) && act != 2'd3;
        x.dif = (mode == MODE_DIF || mode == MODE_BOTH);
        qs = $signed(v.influence_q8);
        if (qs < -10'sd256) begin
            qc = -10'sd256;
        end else if (qs > 10'sd256) begin
            qc = 10'sd256;
        end else begin
            qc = qs;
        end
        // qc * 255 floored by 256: arithmetic shift gives the floor.
        n18 = $signed({qc, 8'h00}) - 18'(qc);
        stp = 10'(n18 >>> 8);
        x.chg = tex && (stp != 10'sd0);
        x.neg = stp < 10'sd0;
        x.mag = x.neg ? 8'(-stp) : stp[7:0];
        tot = 10'(v.weight_0) + 10'(v.weight_1) + 10'(v.weight_2);
        t11 = 11'sd0;
        for (int i = 0; i < NUM_LAYERS; i++) begin
            if (act == 2'(i)) begin
                // Sum of the two other layers, before any change.
                x.den = tot - 10'(x.w[i]);
                if (x.chg) begin
                    x.idx[i] = tex_id;
                    t11 = $signed({3'b000, x.w[i]}) + 11'(stp);
                    if (t11 < 11'sd0) begin
                        x.w[i] = 8'd0;
                    end else if (t11 > 11'sd255) begin
                        x.w[i] = 8'd255;
                    end else begin
                        x.w[i] = t11[7:0];
                    end
                end
            end
        end
        // Blend written as 256*c + q*(p - c).
        for (int i = 0; i < NUM_LANES; i++) begin
            df = $signed({1'b0, pcol[8*i +: 8]}) - $signed({1'b0, v.vtx_rgba[8*i +: 8]});
            pr = qs * df;
            x.bl[i] = 20'(pr);
        end
        return x;
    endfunction

    // Two quotient bits of a restoring division on all three layers.
    function automatic t_item div_bits(input int base, input t_item xi);
        t_item       x;
        int          bt;
        logic [17:0] dd;
        x = xi;
        for (int j = 0; j < 2; j++) begin
            bt = 7 - 2 * base - j;
            dd = 18'(x.den) << bt;
            for (int i = 0; i < NUM_LAYERS; i++) begin
                if (x.rem[i] >= dd) begin
                    x.rem[i] = x.rem[i] - dd;
                    x.quo[i][bt] = 1'b1;
                end
            end
        end
        return x;
    endfunction

    function automatic t_item stage_fn(input int k, input t_item xi);
        t_item              x;
        logic signed [19:0] nn;
        logic [8:0]         up;
        x = xi;
        if (k == STG_MUL1) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                nn = $signed({4'h0, x.color[8*i +: 8], 8'h00}) + $signed(x.bl[i]);
                if (x.dif) begin
                    if (nn < 20'sd0) begin
                        x.color[8*i +: 8] = 8'd0;
                    end else if (nn[19:16] != 4'h0) begin
                        x.color[8*i +: 8] = 8'hFF;
                    end else begin
                        x.color[8*i +: 8] = nn[15:8];
                    end
                end
            end
            for (int i = 0; i < NUM_LAYERS; i++) begin
                x.rem[i] = 18'(16'(x.w[i]) * 16'(x.mag));
                x.quo[i] = 8'd0;
            end
        end else if (k >= STG_DIV1 && k < STG_DIV1 + DIV_STGS) begin
            x = div_bits(k - STG_DIV1, x);
        end else if (k == STG_LOSS) begin
            for (int i = 0; i < NUM_LAYERS; i++) begin
                if (x.chg && x.act != 2'(i) && x.w[i] != 8'd0) begin
                    if (x.neg) begin
                        up = 9'(x.w[i]) + 9'(x.quo[i]);
                        x.w[i] = up[8] ? 8'hFF : up[7:0];
                    end else begin
                        x.w[i] = (x.w[i] >= x.quo[i]) ? x.w[i] - x.quo[i] : 8'd0;
                    end
                end
            end
            x.den = 10'(x.w[0]) + 10'(x.w[1]) + 10'(x.w[2]);
        end else if (k == STG_MUL2) begin
            for (int i = 0; i < NUM_LAYERS; i++) begin
                x.rem[i] = {2'b00, x.w[i], 8'h00} - 18'(x.w[i]);
                x.quo[i] = 8'd0;
            end
        end else if (k >= STG_DIV2 && k < STG_DIV2 + DIV_STGS) begin
            x = div_bits(k - STG_DIV2, x);
        end else if (k == STG_NORM) begin
            if (x.chg && x.den != 10'd255 && x.den != 10'd0) begin
                x.w = x.quo;
            end
        end
        return x;
    endfunction

    t_item            r_stg [NSTG];
    t_item            n_stg [NSTG];
    logic [NSTG-1:0]  r_vld;
    logic [NSTG-1:0]  en;

    always_comb begin
        n_stg[0] = stage_first(i_vtx.data, r_paint_mode, r_active_layer,
                               r_texture_id, r_paint_color);
        for (int k = 1; k < NSTG; k++) begin
            n_stg[k] = stage_fn(k, r_stg[k-1]);
        end
    end

    // A stage may load when it is empty or its beat moves on.
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || o_vtx.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_vtx.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_vtx.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (en[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_vtx.valid = r_vld[NSTG-1];
    assign o_vtx.data  = '{
        new_weight_0:    r_stg[NSTG-1].w[0],
        new_weight_1:    r_stg[NSTG-1].w[1],
        new_weight_2:    r_stg[NSTG-1].w[2],
        new_index_0:     r_stg[NSTG-1].idx[0],
        new_index_1:     r_stg[NSTG-1].idx[1],
        new_index_2:     r_stg[NSTG-1].idx[2],
        new_color:       r_stg[NSTG-1].color,
        weights_changed: r_stg[NSTG-1].chg
    };

endmodule

@@ design/svwp_chk.sv @@
// ----------------------------------------------------------------------------
// Splat weight vertex painter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module svwp_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_w0,
    input logic [7:0] i_w1,
    input logic [7:0] i_w2,
    input logic       i_chg
);
    logic [9:0] wsum;
    assign wsum = 10'(i_w0) + 10'(i_w1) + 10'(i_w2);

    // A result beat waits until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    // Nothing comes out in the cycle after reset.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // With no beat at the end, the pipeline can take a vertex.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with an empty output");

    // Weights flagged as changed never sum above full scale.
    a_wsum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_chg |-> wsum <= 10'd255)
        else $error("painted weights exceed full scale");
endmodule

bind splat_weight_vertex_painter_unit svwp_chk u_svwp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_vtx.ready),
    .i_out_valid (o_vtx.valid),
    .i_out_ready (o_vtx.ready),
    .i_w0        (o_vtx.data.new_weight_0),
    .i_w1        (o_vtx.data.new_weight_1),
    .i_w2        (o_vtx.data.new_weight_2),
    .i_chg       (o_vtx.data.weights_changed)
);

@@ verif/tb_splat_weight_vertex_painter_unit.sv @@
// ----------------------------------------------------------------------------
// Splat weight vertex painter testbench
// Streams vertices through the painter under random stalls and compares each
// painted vertex with an in-bench prediction of texture and diffuse painting.
// ----------------------------------------------------------------------------
module tb_splat_weight_vertex_painter_unit;
    import svwp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH  = 13;
    localparam int STALL_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;

    svwp_chan_if #(.t_data(t_vtx_in))  vtx_in_if ();
    svwp_chan_if #(.t_data(t_vtx_out)) vtx_out_if ();
    svwp_chan_if #(.t_data(t_cfg_wr))  cfg_if ();

    splat_weight_vertex_painter_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx_in_if.sink),
        .o_vtx   (vtx_out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // Shadow copy of the configuration registers.
    logic [1:0]  mode_q;
    logic [1:0]  layer_q;
    logic [7:0]  tex_id_q;
    logic [31:0] paint_color_q;

    // Painted vertices that are still to come out, oldest first.
    t_vtx_out painted_q[$];

    int  error_count = 0;
    bit  sender_idle_on;     // random gaps between input beats
    bit  sink_stall_on;      // random stalls on the output channel
    bit  sink_hold;          // long hold-off of the output channel
    int  idle_cycles = 0;
    int  hold_req = 0;       // hold-offs asked for by the tests
    int  hold_done = 0;      // hold-offs begun by the receiver

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Clamp a signed value to one byte.
    function automatic int clamp_byte(int v);
        return v < 0 ? 0 : (v > 255 ? 255 : v);
    endfunction

    // Predicts the painted vertex from one input vertex and the current registers.
    function automatic t_vtx_out paint_vertex(t_vtx_in v);
        t_vtx_out r;
        int w[3];
        logic [7:0] ix[3];
        int q, qc, prod, stp, a, o1, o2, s1, s2, den, sum, n, c, p;
        logic [31:0] col;
        w[0] = int'(v.weight_0); w[1] = int'(v.weight_1); w[2] = int'(v.weight_2);
        ix[0] = v.index_0; ix[1] = v.index_1; ix[2] = v.index_2;
        q = int'($signed(v.influence_q8));
        col = v.vtx_rgba;
        r.weights_changed = 1'b0;
        if ((mode_q == MODE_TEX || mode_q == MODE_BOTH) && layer_q < 2'd3) begin
            qc = q < -256 ? -256 : (q > 256 ? 256 : q);
            prod = qc * 255;
            // The step rounds toward minus infinity for negative influence.
            stp = prod >= 0 ? prod / 256 : -((-prod + 255) / 256);
            if (stp != 0) begin
                a = int'(layer_q);
                o1 = (a == 0) ? 1 : 0;
                o2 = (a == 2) ? 1 : 2;
                ix[a] = tex_id_q;
                w[a] = clamp_byte(w[a] + stp);
                s1 = w[o1];
                s2 = w[o2];
                den = s1 + s2;
                // The other layers lose the step in proportion to their share.
                if (s1 != 0) w[o1] = clamp_byte(s1 - (s1 * stp) / den);
                if (s2 != 0) w[o2] = clamp_byte(s2 - (s2 * stp) / den);
                sum = w[0] + w[1] + w[2];
                if (sum != 255 && sum != 0) begin
                    for (int i = 0; i < 3; i++) w[i] = (w[i] * 255) / sum;
                end
                r.weights_changed = 1'b1;
            end
        end
        if (mode_q == MODE_DIF || mode_q == MODE_BOTH) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                c = int'(v.vtx_rgba[8*l +: 8]);
                p = int'(paint_color_q[8*l +: 8]);
                n = c * (256 - q) + p * q;
                col[8*l +: 8] = n < 0 ? 8'd0 : 8'(clamp_byte(n >>> 8));
            end
        end
        r.new_weight_0 = 8'(w[0]);
        r.new_weight_1 = 8'(w[1]);
        r.new_weight_2 = 8'(w[2]);
        r.new_index_0 = ix[0];
        r.new_index_1 = ix[1];
        r.new_index_2 = ix[2];
        r.new_color = col;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, field, got, want);
        error_count++;
    endtask

    // Drives random idle bursts when enabled.
    task automatic maybe_idle();
        int gap;
        if (sender_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            vtx_in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sends one vertex beat and records its prediction when it is accepted.
    // Valid stays high afterwards; the next send, an idle burst or a drain
    // decides what the channel carries next.
    task automatic send_vertex(t_vtx_in v);
        maybe_idle();
        vtx_in_if.valid <= 1'b1;
        vtx_in_if.data  <= v;
        do @(posedge i_clk); while (!vtx_in_if.ready);
        painted_q.push_back(paint_vertex(v));
    endtask

    // Writes one register; only called when the pipeline is empty.
    task automatic write_reg(t_cfg_reg idx, logic [31:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, wdata: val};
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_PAINT_MODE:   mode_q = val[1:0];
            CFG_ACTIVE_LAYER: layer_q = val[1:0];
            CFG_TEXTURE_ID:   tex_id_q = val[7:0];
            CFG_PAINT_COLOR:  paint_color_q = val;
            default: ;
        endcase
    endtask

    // Waits until every painted vertex has come out, then lets the pipeline drain.
    task automatic drain();
        vtx_in_if.valid <= 1'b0;
        while (painted_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic configure(logic [1:0] m, logic [1:0] l, logic [7:0] t, logic [31:0] pc);
        drain();
        write_reg(CFG_PAINT_MODE, {30'd0, m});
        write_reg(CFG_ACTIVE_LAYER, {30'd0, l});
        write_reg(CFG_TEXTURE_ID, {24'd0, t});
        write_reg(CFG_PAINT_COLOR, pc);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic t_vtx_in make_vertex(int w0, int w1, int w2, logic [31:0] col, int q);
        t_vtx_in v;
        v.weight_0 = 8'(w0);
        v.weight_1 = 8'(w1);
        v.weight_2 = 8'(w2);
        v.index_0 = 8'($urandom);
        v.index_1 = 8'($urandom);
        v.index_2 = 8'($urandom);
        v.vtx_rgba = col;
        v.influence_q8 = 10'(q);
        return v;
    endfunction

    // Random vertex; weights mostly summing near 255 as a painted terrain holds them.
    function automatic t_vtx_in random_vertex();
        int w0, w1, q;
        int sel;
        sel = $urandom_range(0, 9);
        w0 = $urandom_range(0, 255);
        w1 = $urandom_range(0, 255 - w0);
        case ($urandom_range(0, 5))
            0: q = $urandom_range(0, 1023) - 512;     // whole 10-bit code space
            1: q = $urandom_range(0, 2) - 1;          // near zero step
            default: q = $urandom_range(0, 512) - 256;
        endcase
        if (sel < 7) return make_vertex(w0, w1, 255 - w0 - w1, $urandom, q);
        if (sel == 7) return make_vertex(0, 0, 0, $urandom, q);
        return make_vertex($urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom, q);
    endfunction

    // Corners of influence and weights under the reset configuration.
    task automatic test_directed_extremes();
        send_vertex(make_vertex(85, 85, 85, 32'h0000_0000, 256));
        send_vertex(make_vertex(85, 85, 85, 32'hFFFF_FFFF, -256));
        send_vertex(make_vertex(255, 0, 0, 32'h1234_5678, 0));
        send_vertex(make_vertex(0, 0, 0, 32'h8080_8080, 1));
        send_vertex(make_vertex(0, 0, 0, 32'h8080_8080, -1));
        send_vertex(make_vertex(0, 255, 0, 32'hFFFF_FFFF, 511));
        send_vertex(make_vertex(255, 255, 255, 32'h0000_0000, -512));
        send_vertex(make_vertex(0, 0, 255, 32'hA5A5_5A5A, 128));
        send_vertex(make_vertex(10, 0, 245, 32'h0102_0304, -100));
    endtask

    // Every mode, the unused code included; every layer for the odd modes, layers 0 and 3 for the even ones.
    task automatic test_modes_and_layers();
        for (int m = 0; m < 4; m++) begin
            for (int l = 0; l < 4; l += 3 - (m % 2) * 2) begin
                configure(2'(m), 2'(l), 8'($urandom), $urandom);
                send_vertex(make_vertex(100, 55, 100, $urandom, 200));
                send_vertex(make_vertex(0, 200, 55, $urandom, -300));
            end
        end
    endtask

    task automatic test_random_phases(int count);
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: configure(MODE_BOTH, 2'd0, 8'hFF, 32'hFFFF_FFFF);
                1: configure(MODE_TEX, 2'd2, 8'h00, 32'h0000_0000);
                2: configure(MODE_DIF, 2'd1, 8'h5A, $urandom);
                3: configure(2'd3, 2'd3, 8'hA5, $urandom);
                default: configure(2'($urandom_range(0, 2)), 2'($urandom_range(0, 2)),
                                   8'($urandom), $urandom);
            endcase
            for (int i = 0; i < count; i++) send_vertex(random_vertex());
        end
    endtask

    // Hold the output side off while the sender keeps offering, then pause the
    // sender until everything is out and send a second batch.
    task automatic test_backpressure();
        configure(MODE_BOTH, 2'd1, 8'h33, RST_PAINT_COLOR);
        hold_req++;
        for (int i = 0; i < 40; i++) send_vertex(random_vertex());
        drain();
        for (int i = 0; i < 20; i++) send_vertex(random_vertex());
    endtask

    // Long hold-off of the receiver, counted in cycles here.
    always @(posedge i_clk) begin
        if (sink_hold) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= 60) begin
                sink_hold <= 1'b0;
                idle_cycles <= 0;
            end
        end else if (hold_done != hold_req) begin
            sink_hold <= 1'b1;
            hold_done <= hold_done + 1;
        end
    end

    // Output ready: random stall bursts, or held low during a hold-off.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || sink_hold) begin
            vtx_out_if.ready <= !sink_hold && i_rst_n;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            vtx_out_if.ready <= (stall_left == 1);
        end else if (sink_stall_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 5);
            vtx_out_if.ready <= 1'b0;
        end else begin
            vtx_out_if.ready <= 1'b1;
        end
    end

    // Checks each output beat against the oldest predicted vertex.
    always @(posedge i_clk) begin
        t_vtx_out got, want;
        if (i_rst_n && vtx_out_if.valid && vtx_out_if.ready) begin
            got = vtx_out_if.data;
            if (painted_q.size() == 0) begin
                report_mismatch("unexpected beat", got.new_color, 32'd0);
            end else begin
                want = painted_q.pop_front();
                if (got.new_weight_0 !== want.new_weight_0)
                    report_mismatch("new_weight_0", 32'(got.new_weight_0),
                                    32'(want.new_weight_0));
                if (got.new_weight_1 !== want.new_weight_1)
                    report_mismatch("new_weight_1", 32'(got.new_weight_1),
                                    32'(want.new_weight_1));
                if (got.new_weight_2 !== want.new_weight_2)
                    report_mismatch("new_weight_2", 32'(got.new_weight_2),
                                    32'(want.new_weight_2));
                if (got.new_index_0 !== want.new_index_0)
                    report_mismatch("new_index_0", 32'(got.new_index_0),
                                    32'(want.new_index_0));
                if (got.new_index_1 !== want.new_index_1)
                    report_mismatch("new_index_1", 32'(got.new_index_1),
                                    32'(want.new_index_1));
                if (got.new_index_2 !== want.new_index_2)
                    report_mismatch("new_index_2", 32'(got.new_index_2),
                                    32'(want.new_index_2));
                if (got.new_color !== want.new_color)
                    report_mismatch("new_color", got.new_color, want.new_color);
                if (got.weights_changed !== want.weights_changed)
                    report_mismatch("weights_changed", 32'(got.weights_changed),
                                    32'(want.weights_changed));
            end
        end
    end

    // Watchdog: ends the run after too many cycles with no beat on any channel.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((vtx_in_if.valid && vtx_in_if.ready) || (vtx_out_if.valid && vtx_out_if.ready)
            || (cfg_if.valid && cfg_if.ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        sender_idle_on = 1'b1;
        sink_stall_on = 1'b1;
        i_rst_n = 1'b0;
        vtx_in_if.valid = 1'b0;
        vtx_in_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        mode_q = RST_PAINT_MODE;
        layer_q = RST_ACTIVE_LAYER;
        tex_id_q = RST_TEXTURE_ID;
        paint_color_q = RST_PAINT_COLOR;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_modes_and_layers();
        test_backpressure();
        test_random_phases(85);
        // Final stretch runs at full rate on both sides.
        sender_idle_on = 1'b0;
        sink_stall_on = 1'b0;
        configure(MODE_BOTH, 2'd2, 8'hC3, $urandom);
        for (int i = 0; i < 50; i++) send_vertex(random_vertex());
        drain();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
